FILE: sv/xlbu_pkg.sv
// Package for the x86 logic/shift/bit-test unit.
// Holds the beat payload structs, command and width codes, and flag masks.
// No dependencies.
package xlbu_pkg;

  typedef enum logic [3:0] {
    CMD_AND   = 4'd0,
    CMD_OR    = 4'd1,
    CMD_XOR   = 4'd2,
    CMD_NOT   = 4'd3,
    CMD_TEST  = 4'd4,
    CMD_SHR   = 4'd5,
    CMD_SHL   = 4'd6,
    CMD_SAR   = 4'd7,
    CMD_ROR   = 4'd8,
    CMD_ROL   = 4'd9,
    CMD_BT    = 4'd10,
    CMD_BTS   = 4'd11,
    CMD_BTR   = 4'd12,
    CMD_BTC   = 4'd13,
    CMD_BSWAP = 4'd14
  } cmd_e;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  // flags_written bit positions: cf, zf, sf, pf, of, af
  localparam logic [5:0] FLAGS_NONE  = 6'h00;
  localparam logic [5:0] FLAGS_CF    = 6'h01;
  localparam logic [5:0] FLAGS_LOGIC = 6'h3F;

  localparam int unsigned FLAG_CF_BIT = 0;
  localparam int unsigned FLAG_ZF_BIT = 1;
  localparam int unsigned FLAG_SF_BIT = 2;
  localparam int unsigned FLAG_PF_BIT = 3;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  width_code;
    logic [63:0] dest_value;
    logic [63:0] source_value;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        write_back;
    logic [5:0]  flags_written;
    logic        carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        parity_flag;
    logic        overflow_flag;
    logic        adjust_flag;
  } out_t;

endpackage

FILE: sv/x86_logic_bit_unit_top.sv
// x86 logic-class execution unit: AND/OR/XOR/NOT/TEST, shifts, rotates,
// bit tests and BSWAP, with result, write-back enable and flags.
// Input channel: in_valid_i / in_ready_o carry one instruction (xlbu_pkg::in_t)
// per beat. Output channel: out_valid_o / out_ready_i carry one result beat
// (xlbu_pkg::out_t) per instruction, in order.
// Path: a beat accepted on in_valid_i / in_ready_o is captured in the input
// register, then its result in the result register, which drives out_data_o.
// Throughput, unstalled: one instruction per cycle; the datapath between the two
// registers is a single combinational pass with no state kept between items.
// Reset (rst_ni low, asynchronous) empties both stages; no beat is lost or
// replayed because none is held. When the receiver stalls, the result register
// holds its beat, the input register fills behind it, and in_ready_o drops
// only once both stages are occupied.
module x86_logic_bit_unit_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xlbu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xlbu_pkg::out_t out_data_o
);
  import xlbu_pkg::*;

  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  out_t alu_res;
  logic out_free;
  logic s1_load;
  logic out_load;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | out_free;
  assign s1_load    = in_valid_i & in_ready_o;
  assign out_load   = s1_valid_q & out_free;

  assign s1_valid_d  = s1_load | (s1_valid_q & ~out_free);
  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q <= alu_res;
    end
  end

  xlbu_alu u_alu (
    .op_i  (s1_data_q),
    .res_o (alu_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/xlbu_alu.sv
// Combinational datapath of the logic/shift/bit-test unit.
// Depends on xlbu_pkg for the payload structs and command codes.
module xlbu_alu (
  input  xlbu_pkg::in_t  op_i,
  output xlbu_pkg::out_t res_o
);
  import xlbu_pkg::*;

  width_e       width;
  logic [63:0]  wmask;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [5:0]   cnt;
  logic [5:0]   idx;
  logic [5:0]   rot;
  logic [63:0]  sel;
  logic         a_sign;
  logic [63:0]  sar_ext;
  logic [63:0]  sar_res;
  logic [15:0]  ror8_x;
  logic [31:0]  ror16_x;
  logic [63:0]  ror32_x;
  logic [127:0] ror64_x;
  logic [15:0]  rol8_x;
  logic [31:0]  rol16_x;
  logic [63:0]  rol32_x;
  logic [127:0] rol64_x;
  logic [63:0]  ror_res;
  logic [63:0]  rol_res;
  logic [63:0]  bswap_res;
  logic [63:0]  res;
  logic [63:0]  res_m;
  logic         wb;
  logic [5:0]   fw;
  logic         cf;
  logic         res_sign;

  assign width = width_e'(op_i.width_code);
  assign b     = op_i.source_value;

  always_comb begin
    unique case (width)
      W8: begin
        wmask   = 64'h0000_0000_0000_00FF;
        cnt     = {1'b0, b[4:0]};
        idx     = {3'b0, b[2:0]};
        rot     = {3'b0, cnt[2:0]};
        a_sign  = op_i.dest_value[7];
      end
      W16: begin
        wmask   = 64'h0000_0000_0000_FFFF;
        cnt     = {1'b0, b[4:0]};
        idx     = {2'b0, b[3:0]};
        rot     = {2'b0, cnt[3:0]};
        a_sign  = op_i.dest_value[15];
      end
      W32: begin
        wmask   = 64'h0000_0000_FFFF_FFFF;
        cnt     = {1'b0, b[4:0]};
        idx     = {1'b0, b[4:0]};
        rot     = {1'b0, cnt[4:0]};
        a_sign  = op_i.dest_value[31];
      end
      default: begin
        wmask   = 64'hFFFF_FFFF_FFFF_FFFF;
        cnt     = b[5:0];
        idx     = b[5:0];
        rot     = cnt;
        a_sign  = op_i.dest_value[63];
      end
    endcase
  end

  assign a = op_i.dest_value & wmask;

  // rotates: shift a doubled copy, count already reduced modulo the width
  assign ror8_x  = {a[7:0], a[7:0]} >> rot[2:0];
  assign ror16_x = {a[15:0], a[15:0]} >> rot[3:0];
  assign ror32_x = {a[31:0], a[31:0]} >> rot[4:0];
  assign ror64_x = {a, a} >> rot;
  assign rol8_x  = {a[7:0], a[7:0]} << rot[2:0];
  assign rol16_x = {a[15:0], a[15:0]} << rot[3:0];
  assign rol32_x = {a[31:0], a[31:0]} << rot[4:0];
  assign rol64_x = {a, a} << rot;

  always_comb begin
    unique case (width)
      W8: begin
        ror_res = {56'b0, ror8_x[7:0]};
        rol_res = {56'b0, rol8_x[15:8]};
      end
      W16: begin
        ror_res = {48'b0, ror16_x[15:0]};
        rol_res = {48'b0, rol16_x[31:16]};
      end
      W32: begin
        ror_res = {32'b0, ror32_x[31:0]};
        rol_res = {32'b0, rol32_x[63:32]};
      end
      default: begin
        ror_res = ror64_x[63:0];
        rol_res = rol64_x[127:64];
      end
    endcase
  end

  // SAR at narrow widths: counts past the width fill with the sign bit
  assign sar_ext = a_sign ? (a | ~wmask) : a;
  assign sar_res = 64'($signed(sar_ext) >>> cnt);

  assign sel = 64'd1 << idx;

  always_comb begin
    unique case (width)
      W32:     bswap_res = {32'b0, a[7:0], a[15:8], a[23:16], a[31:24]};
      W64:     bswap_res = {a[7:0], a[15:8], a[23:16], a[31:24],
                            a[39:32], a[47:40], a[55:48], a[63:56]};
      default: bswap_res = 64'b0;
    endcase
  end

  always_comb begin
    res = 64'b0;
    wb  = 1'b0;
    fw  = FLAGS_NONE;
    cf  = 1'b0;
    unique case (cmd_e'(op_i.command))
      CMD_AND:   begin res = a & b;     wb = 1'b1; fw = FLAGS_LOGIC; end
      CMD_OR:    begin res = a | b;     wb = 1'b1; fw = FLAGS_LOGIC; end
      CMD_XOR:   begin res = a ^ b;     wb = 1'b1; fw = FLAGS_LOGIC; end
      CMD_NOT:   begin res = ~a;        wb = 1'b1; end
      CMD_TEST:  begin res = a & b;     fw = FLAGS_LOGIC; end
      CMD_SHR:   begin res = a >> cnt;  wb = 1'b1; end
      CMD_SHL:   begin res = a << cnt;  wb = 1'b1; end
      CMD_SAR:   begin res = sar_res;   wb = 1'b1; end
      CMD_ROR:   begin res = ror_res;   wb = 1'b1; end
      CMD_ROL:   begin res = rol_res;   wb = 1'b1; end
      CMD_BT:    begin res = a;         cf = a[idx]; fw = FLAGS_CF; end
      CMD_BTS:   begin res = a | sel;   cf = a[idx]; fw = FLAGS_CF; wb = 1'b1; end
      CMD_BTR:   begin res = a & ~sel;  cf = a[idx]; fw = FLAGS_CF; wb = 1'b1; end
      CMD_BTC:   begin res = a ^ sel;   cf = a[idx]; fw = FLAGS_CF; wb = 1'b1; end
      CMD_BSWAP: begin res = bswap_res; wb = 1'b1; end
      default:   begin res = 64'b0; end
    endcase
  end

  assign res_m = res & wmask;

  always_comb begin
    unique case (width)
      W8:      res_sign = res_m[7];
      W16:     res_sign = res_m[15];
      W32:     res_sign = res_m[31];
      default: res_sign = res_m[63];
    endcase
  end

  always_comb begin
    res_o               = '0;
    res_o.result_value  = res_m;
    res_o.write_back    = wb;
    res_o.flags_written = fw;
    res_o.carry_flag    = fw[FLAG_CF_BIT] & cf;
    res_o.zero_flag     = fw[FLAG_ZF_BIT] & (res_m == 64'b0);
    res_o.sign_flag     = fw[FLAG_SF_BIT] & res_sign;
    res_o.parity_flag   = fw[FLAG_PF_BIT] & ~(^res_m[7:0]);
    // OF and AF are written as cleared by the logical ops
    res_o.overflow_flag = 1'b0;
    res_o.adjust_flag   = 1'b0;
  end

endmodule

FILE: sv/xlbu_checker.sv
// Port-level checks for x86_logic_bit_unit_top, attached by bind.
// Depends on xlbu_pkg for the payload structs and flag masks.
module xlbu_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input xlbu_pkg::out_t out_data_o
);
  import xlbu_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // an accepted instruction has a result beat showing after both registers
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted instruction produced no result beat");

  // only three flag groups exist: none, CF only, all logic flags
  a_fw_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.flags_written == FLAGS_NONE ||
                     out_data_o.flags_written == FLAGS_CF ||
                     out_data_o.flags_written == FLAGS_LOGIC))
    else $error("unexpected flags_written mask");

  // a flag that is not written reads as zero
  a_flag_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.carry_flag  || out_data_o.flags_written[FLAG_CF_BIT]) &&
                    (!out_data_o.zero_flag   || out_data_o.flags_written[FLAG_ZF_BIT]) &&
                    (!out_data_o.sign_flag   || out_data_o.flags_written[FLAG_SF_BIT]) &&
                    (!out_data_o.parity_flag || out_data_o.flags_written[FLAG_PF_BIT]))
    else $error("flag set without its written bit");

  // OF/AF are always cleared, and a nonzero result never reports ZF
  a_zf_of_af: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.overflow_flag && !out_data_o.adjust_flag &&
                    !(out_data_o.zero_flag && out_data_o.result_value != 64'b0))
    else $error("OF/AF set or ZF with nonzero result");

endmodule

bind x86_logic_bit_unit_top xlbu_props u_xlbu_props (.*);

FILE: bench/xlbu_checker.sv
// Scoreboard for the x86 logic/shift/bit-test unit: watches both beat channels,
// predicts each result from the accepted instruction and compares field by field.
// Depends on xlbu_pkg for the payload structs, command codes and flag masks.
module xlbu_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  xlbu_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  xlbu_pkg::out_t out_data_i,
  output int unsigned    mismatches_o,
  output int unsigned    pending_o,
  output int unsigned    compared_o
);
  import xlbu_pkg::*;

  out_t expected_results[$];

  function automatic out_t predict_logic_result(in_t ins);
    out_t        r;
    int unsigned bits, cnt, idx, rot;
    logic [63:0] mask, a, b, res, sel, ext;
    logic [5:0]  fw;
    logic        cf, wb;
    bits = 8 << ins.width_code;
    mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
    a    = ins.dest_value & mask;
    b    = ins.source_value;
    // x86 masks shift counts to 5 bits below 64-bit width
    cnt  = (bits == 64) ? 32'(b[5:0]) : 32'(b[4:0]);
    idx  = int'(b[5:0]) & (bits - 1);
    rot  = cnt % bits;
    sel  = 64'd1 << idx;
    res  = '0;
    wb   = 1'b0;
    fw   = FLAGS_NONE;
    cf   = 1'b0;
    unique case (ins.command)
      CMD_AND: begin
        res = a & b; wb = 1'b1; fw = FLAGS_LOGIC;
      end
      CMD_OR: begin
        res = a | b; wb = 1'b1; fw = FLAGS_LOGIC;
      end
      CMD_XOR: begin
        res = a ^ b; wb = 1'b1; fw = FLAGS_LOGIC;
      end
      CMD_NOT: begin
        res = ~a; wb = 1'b1;
      end
      CMD_TEST: begin
        res = a & b; fw = FLAGS_LOGIC;
      end
      CMD_SHR: begin
        res = a >> cnt; wb = 1'b1;
      end
      CMD_SHL: begin
        res = a << cnt; wb = 1'b1;
      end
      CMD_SAR: begin
        ext = a[bits-1] ? (a | ~mask) : a;
        res = $signed(ext) >>> cnt;
        wb  = 1'b1;
      end
      CMD_ROR: begin
        res = (rot == 0) ? a : ((a >> rot) | (a << (bits - rot)));
        wb  = 1'b1;
      end
      CMD_ROL: begin
        res = (rot == 0) ? a : ((a << rot) | (a >> (bits - rot)));
        wb  = 1'b1;
      end
      CMD_BT: begin
        res = a; cf = a[idx]; fw = FLAGS_CF;
      end
      CMD_BTS: begin
        res = a | sel; cf = a[idx]; fw = FLAGS_CF; wb = 1'b1;
      end
      CMD_BTR: begin
        res = a & ~sel; cf = a[idx]; fw = FLAGS_CF; wb = 1'b1;
      end
      CMD_BTC: begin
        res = a ^ sel; cf = a[idx]; fw = FLAGS_CF; wb = 1'b1;
      end
      CMD_BSWAP: begin
        // 8/16-bit byte swap is undefined on x86; this unit writes zero
        if (bits >= 32) begin
          for (int i = 0; i < bits / 8; i++) begin
            res = (res << 8) | ((a >> (8 * i)) & 64'hFF);
          end
        end
        wb = 1'b1;
      end
      default: ;
    endcase
    res &= mask;

    r               = '0;
    r.result_value  = res;
    r.write_back    = wb;
    r.flags_written = fw;
    r.carry_flag    = fw[FLAG_CF_BIT] ? cf : 1'b0;
    r.zero_flag     = fw[FLAG_ZF_BIT] ? (res == '0) : 1'b0;
    r.sign_flag     = fw[FLAG_SF_BIT] ? res[bits-1] : 1'b0;
    r.parity_flag   = fw[FLAG_PF_BIT] ? ~^res[7:0] : 1'b0;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      // the result side first: a beat leaving now is older than one arriving
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat %h with no instruction outstanding", out_data_i);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("result_value", want.result_value, out_data_i.result_value);
          compare_field("write_back", 64'(want.write_back),
                        64'(out_data_i.write_back));
          compare_field("flags_written", 64'(want.flags_written),
                        64'(out_data_i.flags_written));
          compare_field("carry_flag", 64'(want.carry_flag),
                        64'(out_data_i.carry_flag));
          compare_field("zero_flag", 64'(want.zero_flag),
                        64'(out_data_i.zero_flag));
          compare_field("sign_flag", 64'(want.sign_flag),
                        64'(out_data_i.sign_flag));
          compare_field("parity_flag", 64'(want.parity_flag),
                        64'(out_data_i.parity_flag));
          compare_field("overflow_flag", 64'(want.overflow_flag),
                        64'(out_data_i.overflow_flag));
          compare_field("adjust_flag", 64'(want.adjust_flag),
                        64'(out_data_i.adjust_flag));
          compared_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_logic_result(in_data_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for x86_logic_bit_unit_top: clock, reset, instruction stimulus,
// result-side backpressure, watchdog and verdict.
// Depends on xlbu_pkg, the unit itself and xlbu_checker.
module tb_top;
  import xlbu_pkg::*;

  localparam logic [3:0]  CMD_UNUSED     = 4'd15;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BEATS    = 235;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  int unsigned mismatches, pending, compared;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned holds_wanted = 0;
  int unsigned holds_done   = 0;
  int unsigned sent_beats   = 0;
  int unsigned idle_cycles  = 0;

  always #2 clk_i = ~clk_i;

  x86_logic_bit_unit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  xlbu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  function automatic in_t make_beat(logic [3:0] cmd, width_e w, logic [63:0] d,
                                    logic [63:0] s);
    in_t b;
    b.command      = cmd;
    b.width_code   = w;
    b.dest_value   = d;
    b.source_value = s;
    return b;
  endfunction

  function automatic logic [63:0] random_operand();
    unique case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      4: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t random_beat();
    in_t b;
    b.command      = ($urandom_range(49) == 0) ? CMD_UNUSED
                                               : 4'($urandom_range(int'(CMD_BSWAP)));
    b.width_code   = 2'($urandom_range(3));
    b.dest_value   = random_operand();
    // counts and bit indexes mostly small, so masking and wrap are hit often
    b.source_value = ($urandom_range(1) == 0) ? 64'($urandom_range(130))
                                              : random_operand();
    return b;
  endfunction

  // valid stays up across back-to-back beats; only lowered during a gap
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_beats++;
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(random_beat());
  endtask

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_wanted) begin
        out_ready_i <= 1'b0;
        for (int unsigned k = 1; k < HOLD_CYCLES; k++) @(posedge clk_i);
        holds_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("x86_logic_bit_unit_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: width extremes, count/index masking, every command
    send_beat(make_beat(CMD_AND,   W64, '1, '1));
    send_beat(make_beat(CMD_AND,   W8,  '1, 64'hFFFF_FFFF_FFFF_FF00));
    send_beat(make_beat(CMD_OR,    W16, 64'h8000, 64'h0001));
    send_beat(make_beat(CMD_XOR,   W32, 64'hDEAD_BEEF_1234_5678, 64'h0000_0000_1234_5678));
    send_beat(make_beat(CMD_NOT,   W64, 64'h0F0F_0000_FFFF_1234, '0));
    send_beat(make_beat(CMD_TEST,  W8,  64'h80, 64'hFF));
    send_beat(make_beat(CMD_SHR,   W8,  '1, 64'd31));
    send_beat(make_beat(CMD_SHL,   W16, 64'h00FF, 64'd20));
    send_beat(make_beat(CMD_SAR,   W8,  64'h80, 64'd15));
    send_beat(make_beat(CMD_SAR,   W64, 64'h8000_0000_0000_0001, 64'd63));
    send_beat(make_beat(CMD_SAR,   W32, 64'h7FFF_FFFF, 64'd33));
    send_beat(make_beat(CMD_SHR,   W64, '1, 64'd67));
    send_beat(make_beat(CMD_SHL,   W32, 64'h1234_5678, 64'd32));
    send_beat(make_beat(CMD_ROR,   W8,  64'h81, 64'd9));
    send_beat(make_beat(CMD_ROL,   W16, 64'h8001, 64'd31));
    send_beat(make_beat(CMD_ROR,   W64, 64'h0123_4567_89AB_CDEF, 64'h41));
    send_beat(make_beat(CMD_BT,    W64, 64'h8000_0000_0000_0000, 64'd63));
    send_beat(make_beat(CMD_BT,    W8,  64'h80, 64'hFF));
    send_beat(make_beat(CMD_BTS,   W16, 64'h0000, 64'd15));
    send_beat(make_beat(CMD_BTR,   W32, 64'hFFFF_FFFF, 64'd40));
    send_beat(make_beat(CMD_BTC,   W64, 64'h0, 64'hFFFF_FFFF_FFFF_FFC0));
    send_beat(make_beat(CMD_BSWAP, W8,  64'hAB, '0));
    send_beat(make_beat(CMD_BSWAP, W16, 64'hABCD, '0));
    send_beat(make_beat(CMD_BSWAP, W32, 64'h1122_3344, '0));
    send_beat(make_beat(CMD_BSWAP, W64, 64'h1122_3344_5566_7788, '0));
    send_beat(make_beat(CMD_UNUSED, W64, '1, '1));

    // back-to-back with a long result-side hold-off at the start
    holds_wanted++;
    send_random(PHASE_BEATS);
    gap_pct = 48;
    send_random(PHASE_BEATS);
    gap_pct   = 0;
    stall_pct = 48;
    send_random(PHASE_BEATS);
    gap_pct   = 35;
    stall_pct = 35;
    send_random(PHASE_BEATS);

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d instruction beats over four idle/stall mixes and one %0d-cycle",
             sent_beats, HOLD_CYCLES);
    $display("result hold-off; %0d result beats compared, %0d mismatches.",
             compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("x86_logic_bit_unit_top verification clean");
    end else begin
      $display("x86_logic_bit_unit_top verification failed");
    end
    $finish;
  end

endmodule

FILE: x86_logic_bit_unit_top.f
sv/xlbu_pkg.sv
sv/xlbu_alu.sv
sv/x86_logic_bit_unit_top.sv
sv/xlbu_checker.sv
bench/xlbu_checker.sv
bench/tb_top.sv
